// ===== sv/fsl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsl_pkg
// Types, codes and the length load table for the frame sequencer block.
// ----------------------------------------------------------------------------
package fsl_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  // register offsets from the base of the audio register window
  localparam logic [4:0] REG_HALT   = 5'h00;
  localparam logic [4:0] REG_LENGTH = 5'h03;
  localparam logic [4:0] REG_STATUS = 5'h15;
  localparam logic [4:0] REG_FRAME  = 5'h17;

  // frame sequencer step points
  localparam logic [15:0] STEP_Q1      = 16'd14913;
  localparam logic [15:0] STEP_IRQ_A   = 16'd29828;
  localparam logic [15:0] STEP_IRQ_B   = 16'd29829;
  localparam logic [15:0] STEP_WRAP_4  = 16'd29830;
  localparam logic [15:0] STEP_Q4      = 16'd37281;
  localparam logic [15:0] STEP_WRAP_5  = 16'd37282;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
  } out_item_t;

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;   5'd1:  val = 8'd254;  5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;    5'd4:  val = 8'd40;   5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;   5'd7:  val = 8'd6;    5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;    5'd10: val = 8'd60;   5'd11: val = 8'd10;
      5'd12: val = 8'd14;   5'd13: val = 8'd12;   5'd14: val = 8'd26;
      5'd15: val = 8'd14;   5'd16: val = 8'd12;   5'd17: val = 8'd16;
      5'd18: val = 8'd24;   5'd19: val = 8'd18;   5'd20: val = 8'd48;
      5'd21: val = 8'd20;   5'd22: val = 8'd96;   5'd23: val = 8'd22;
      5'd24: val = 8'd192;  5'd25: val = 8'd24;   5'd26: val = 8'd72;
      5'd27: val = 8'd26;   5'd28: val = 8'd16;   5'd29: val = 8'd28;
      5'd30: val = 8'd32;   5'd31: val = 8'd30;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/frame_sequencer_length_counter.sv =====
// ----------------------------------------------------------------------------
// frame_sequencer_length_counter
// Frame sequencer with one channel's length counter, one result per item.
// ----------------------------------------------------------------------------
// Path: an item is taken into the input register, then the state update writes
//   its result into the result register, where a stall on the output holds it.
// Throughput: one item per cycle while the output is not stalled; the state update is a single step.
// Reset: rst_ni clears all sequencer and counter state and both valid flags.
module frame_sequencer_length_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fsl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsl_pkg::out_item_t out_data_o
);
  import fsl_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      advance;
  logic      fire;

  // result register free, or being emptied this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  fsl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/fsl_core.sv =====
// ----------------------------------------------------------------------------
// fsl_core
// Sequencer and length counter state, updated once per item.
// ----------------------------------------------------------------------------
module fsl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  fsl_pkg::in_item_t item_i,
  output fsl_pkg::out_item_t result_o
);
  import fsl_pkg::*;

  logic [15:0] step_q, step_d;
  logic [15:0] target_q, target_d;
  logic        pending_q, pending_d;
  logic        five_q, five_d;
  logic        inhibit_q, inhibit_d;
  logic        irq_q, irq_d;
  logic [7:0]  len_q, len_d;
  logic        halt_q, halt_d;
  logic        enable_q, enable_d;

  cmd_e        cmd;
  logic        reset_hit;
  logic [15:0] step_base;
  logic        len_clock;
  logic        irq_set;
  logic [7:0]  rd;

  always_comb begin
    cmd        = cmd_e'(item_i.command);
    step_d     = step_q;
    target_d   = target_q;
    pending_d  = pending_q;
    five_d     = five_q;
    inhibit_d  = inhibit_q;
    irq_d      = irq_q;
    len_d      = len_q;
    halt_d     = halt_q;
    enable_d   = enable_q;
    rd         = 8'd0;
    reset_hit  = pending_q && (target_q == step_q);
    step_base  = reset_hit ? 16'd0 : step_q;
    len_clock  = 1'b0;
    irq_set    = 1'b0;

    case (cmd)
      CMD_TICK: begin
        if (reset_hit) begin
          pending_d = 1'b0;
        end
        // delayed reset and the quarter-frame points never coincide
        len_clock = (reset_hit && five_q) || (step_base == STEP_Q1) ||
                    (step_base == STEP_Q4) || (!five_q && step_base == STEP_IRQ_B);
        irq_set   = !five_q && !inhibit_q &&
                    ((step_base == STEP_IRQ_A) || (step_base == STEP_IRQ_B) ||
                     (step_base == STEP_WRAP_4));
        if ((step_base == STEP_WRAP_5) || (!five_q && step_base == STEP_WRAP_4)) begin
          step_d = 16'd0;
        end else begin
          step_d = step_base + 16'd1;
        end
        if (len_clock && !halt_q && (len_q != 8'd0)) begin
          len_d = len_q - 8'd1;
        end
        if (irq_set) begin
          irq_d = 1'b1;
        end
      end
      CMD_READ: begin
        if (item_i.reg_offset == REG_STATUS) begin
          rd    = {1'b0, irq_q, 5'd0, (len_q != 8'd0)};
          irq_d = 1'b0;
        end
      end
      CMD_WRITE: begin
        case (item_i.reg_offset)
          REG_HALT: halt_d = item_i.write_data[5];
          REG_LENGTH: begin
            if (enable_q) begin
              len_d = length_lookup(item_i.write_data[7:3]);
            end
          end
          REG_STATUS: begin
            enable_d = item_i.write_data[0];
            if (!item_i.write_data[0]) begin
              len_d = 8'd0;
            end
            irq_d = 1'b0;
          end
          REG_FRAME: begin
            inhibit_d = item_i.write_data[6];
            five_d    = item_i.write_data[7];
            target_d  = step_q + (step_q[0] ? 16'd2 : 16'd3);
            pending_d = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result_o.read_data = rd;
    result_o.irq_out   = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      target_q  <= '0;
      pending_q <= 1'b0;
      five_q    <= 1'b0;
      inhibit_q <= 1'b0;
      irq_q     <= 1'b0;
      len_q     <= '0;
      halt_q    <= 1'b0;
      enable_q  <= 1'b0;
    end else if (fire_i) begin
      step_q    <= step_d;
      target_q  <= target_d;
      pending_q <= pending_d;
      five_q    <= five_d;
      inhibit_q <= inhibit_d;
      irq_q     <= irq_d;
      len_q     <= len_d;
      halt_q    <= halt_d;
      enable_q  <= enable_d;
    end
  end

endmodule

// ===== sv/fsl_checker.sv =====
// ----------------------------------------------------------------------------
// fsl_checker
// Port-level checks on the frame sequencer block, bound to the top level.
// ----------------------------------------------------------------------------
module fsl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fsl_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fsl_pkg::out_item_t out_data_o
);
  import fsl_pkg::*;

  // a stalled result stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // only the length and interrupt bits of the status byte may be set
  a_status_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.read_data & 8'hBE) == 8'h00))
    else $error("unused status bits set");

  // a status read that reports the interrupt clears it
  a_read_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_data[6] |-> !out_data_o.irq_out)
    else $error("interrupt not cleared by status read");

endmodule

bind frame_sequencer_length_counter fsl_checker u_fsl_checker (.*);
